[src/rmc_pkg.sv]
// Shared types, constants and pixel helpers for the RGB 7x7 closing block.
// No dependencies; used by the top level and the port checker.
package rmc_pkg;

    // Default sizing of the window and the line buffers
    localparam int MAX_LINE_WIDTH_DEF = 1024;
    localparam int WINDOW_SIZE_DEF    = 7;

    // Configuration register layout
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam int HEIGHT_MAX   = (1 << CFG_HEIGHT_W) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd768;

    // Item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    localparam int CHAN_W = 8;
    localparam int RGB_W  = 3 * CHAN_W;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    // Per-channel maximum
    function automatic rgb_t rgb_max(input rgb_t a, input rgb_t b);
        rgb_t m;
        m.r = (a.r > b.r) ? a.r : b.r;
        m.g = (a.g > b.g) ? a.g : b.g;
        m.b = (a.b > b.b) ? a.b : b.b;
        return m;
    endfunction

    // Per-channel minimum
    function automatic rgb_t rgb_min(input rgb_t a, input rgb_t b);
        rgb_t m;
        m.r = (a.r < b.r) ? a.r : b.r;
        m.g = (a.g < b.g) ? a.g : b.g;
        m.b = (a.b < b.b) ? a.b : b.b;
        return m;
    endfunction

endpackage

[src/rmc_line_buf.sv]
// Column line buffer: one memory word per column holding the previous lines.
// Synchronous read into an output register, with write-to-read forwarding.
module rmc_line_buf #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 144,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write back the updated column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read; take the word being written when both hit the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/rgb_morphological_closing_7x7.sv]
// Streaming RGB morphological closing (square max, then square min) per channel.
// Depends on rmc_pkg and rmc_line_buf.
//
// One item per clock: an input transfer can happen in every cycle, and in_ready drops only
// while a finished pixel sits in the output register and out_ready is low. Each item passes
// via s1-s4 and the output register; the rate is set by both column line buffers, each doing
// one read-modify-write of a column word per item. The result for pixel k of a frame leaves
// with frame item k + (W-1)*width + (W-1); that many drain items (mode 1) after the last
// pixel flush the frame, and frame_last marks its final pixel. Border ring pixels and frames
// smaller than the window come out as the input. Line buffers need no clearing after reset.
module rgb_morphological_closing_7x7 #(
    parameter int MAX_LINE_WIDTH = rmc_pkg::MAX_LINE_WIDTH_DEF,
    parameter int WINDOW_SIZE    = rmc_pkg::WINDOW_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [rmc_pkg::CHAN_W-1:0]       red_in,
    input  logic [rmc_pkg::CHAN_W-1:0]       green_in,
    input  logic [rmc_pkg::CHAN_W-1:0]       blue_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rmc_pkg::CHAN_W-1:0]       red_out,
    output logic [rmc_pkg::CHAN_W-1:0]       green_out,
    output logic [rmc_pkg::CHAN_W-1:0]       blue_out,
    output logic                             frame_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int HALF  = WINDOW_SIZE / 2;
    localparam int SPAN  = 2 * HALF;
    localparam int XW    = $clog2(MAX_LINE_WIDTH);
    localparam int WW    = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CW    = (WW > rmc_pkg::CFG_WIDTH_W) ? WW : rmc_pkg::CFG_WIDTH_W;
    localparam int YW    = rmc_pkg::CFG_HEIGHT_W + 1;
    localparam int JW    = $clog2(MAX_LINE_WIDTH * (rmc_pkg::HEIGHT_MAX + SPAN) + SPAN + 1) + 1;
    localparam int LBW   = SPAN * rmc_pkg::RGB_W;
    localparam int RGBW  = rmc_pkg::RGB_W;

    // Configuration
    logic [rmc_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [rmc_pkg::CFG_HEIGHT_W-1:0] height_reg;
    logic                             cfg_hit;

    // Effective frame geometry
    logic [CW-1:0]                    width_wide;
    logic [WW-1:0]                    eff_w;
    logic [WW-1:0]                    w_m1;
    logic [rmc_pkg::CFG_HEIGHT_W-1:0] eff_h;
    logic                             small_frame;
    logic [JW-1:0]                    lat;
    logic [JW-1:0]                    total;
    logic [JW-1:0]                    end_j;

    // Frame counters
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [JW-1:0] j_reg, j_next;
    logic          en;
    logic          accept;
    logic          counted;
    logic          is_last;

    // Pipeline stage registers
    logic          s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic          s1_emit_reg, s2_emit_reg, s3_emit_reg, s4_emit_reg;
    logic          s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [XW-1:0] s1_x_reg, s2_x_reg, s3_x_reg, s4_x_reg;
    logic [YW-1:0] s2_y_reg, s3_y_reg, s4_y_reg, s1_y_reg;
    rmc_pkg::rgb_t s1_pix_reg;
    rmc_pkg::rgb_t s3_s_reg;

    // Windows as column reductions plus a center delay
    rmc_pkg::rgb_t cmax_reg [0:SPAN];
    rmc_pkg::rgb_t cmin_reg [0:SPAN];
    rmc_pkg::rgb_t dly1_reg [0:HALF];
    rmc_pkg::rgb_t dly2_reg [0:HALF];

    // Line buffer ports
    logic [LBW-1:0] lb1_rd, lb1_wr, lb2_rd, lb2_wr;
    rmc_pkg::rgb_t  col1 [0:SPAN];
    rmc_pkg::rgb_t  col2 [0:SPAN];
    rmc_pkg::rgb_t  col1_max, col2_min;
    rmc_pkg::rgb_t  stage1_val, stage2_val;
    rmc_pkg::rgb_t  win_max, win_min;

    // Stage coordinates
    logic [WW-1:0] xq, xk;
    logic [YW-1:0] yq, yk;
    logic          border1, border2;

    // Output register
    logic          out_v_reg;
    rmc_pkg::rgb_t out_pix_reg;
    logic          out_last_reg;

    // Frame geometry from the registers
    always_comb
    begin
        width_wide = CW'(width_reg);
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (width_wide > CW'(MAX_LINE_WIDTH))
        begin
            eff_w = WW'(MAX_LINE_WIDTH);
        end
        else
        begin
            eff_w = width_wide[WW-1:0];
        end
        eff_h       = (height_reg == '0) ? rmc_pkg::CFG_HEIGHT_W'(1) : height_reg;
        w_m1        = eff_w - WW'(1);
        small_frame = (eff_w < WW'(WINDOW_SIZE)) ||
                      (eff_h < rmc_pkg::CFG_HEIGHT_W'(WINDOW_SIZE));
        lat         = JW'(SPAN) * JW'(eff_w) + JW'(SPAN);
        total       = JW'(eff_w) * JW'(eff_h);
        end_j       = lat + total - JW'(1);
    end

    // Handshakes: stall the whole pipe only on a held output
    assign en        = !out_v_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && en;
    assign cfg_hit   = cfg_valid &&
                       ((cfg_index == rmc_pkg::REG_IMAGE_WIDTH) ||
                        (cfg_index == rmc_pkg::REG_IMAGE_HEIGHT));

    // Drop pixels past the frame and drains before its end
    always_comb
    begin
        if (mode == rmc_pkg::MODE_PIXEL)
        begin
            counted = accept && (y_reg < YW'(eff_h));
        end
        else
        begin
            counted = accept && (y_reg >= YW'(eff_h));
        end
        is_last = (j_reg == end_j);
    end

    // Advance the frame position
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        j_next = j_reg;
        if (cfg_hit)
        begin
            x_next = '0;
            y_next = '0;
            j_next = '0;
        end
        else if (counted)
        begin
            if (is_last)
            begin
                x_next = '0;
                y_next = '0;
                j_next = '0;
            end
            else
            begin
                j_next = j_reg + JW'(1);
                if (x_reg == w_m1[XW-1:0])
                begin
                    x_next = '0;
                    y_next = y_reg + YW'(1);
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            j_reg <= j_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rmc_pkg::WIDTH_RESET;
            height_reg <= rmc_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rmc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[rmc_pkg::CFG_WIDTH_W-1:0];
                rmc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= counted;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            out_v_reg <= s4_v_reg && s4_emit_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pix_reg  <= '{r: red_in, g: green_in, b: blue_in};
            s1_x_reg    <= x_reg;
            s1_y_reg    <= y_reg;
            s1_emit_reg <= (j_reg >= lat);
            s1_last_reg <= is_last;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_emit_reg <= s1_emit_reg;
            s2_last_reg <= s1_last_reg;
            s3_s_reg    <= stage1_val;
            s3_x_reg    <= s2_x_reg;
            s3_y_reg    <= s2_y_reg;
            s3_emit_reg <= s2_emit_reg;
            s3_last_reg <= s2_last_reg;
            s4_x_reg    <= s3_x_reg;
            s4_y_reg    <= s3_y_reg;
            s4_emit_reg <= s3_emit_reg;
            s4_last_reg <= s3_last_reg;
            out_pix_reg  <= stage2_val;
            out_last_reg <= s4_last_reg;
        end
    end

    // Input column: stored lines plus the new pixel; shifted word goes back
    always_comb
    begin
        for (int i = 0; i < SPAN; i++)
        begin
            col1[i] = lb1_rd[i*RGBW +: RGBW];
            col2[i] = lb2_rd[i*RGBW +: RGBW];
        end
        col1[SPAN] = s1_pix_reg;
        col2[SPAN] = s3_s_reg;
        for (int i = 0; i < SPAN; i++)
        begin
            lb1_wr[i*RGBW +: RGBW] = col1[i+1];
            lb2_wr[i*RGBW +: RGBW] = col2[i+1];
        end
        col1_max = col1[0];
        col2_min = col2[0];
        for (int i = 1; i <= SPAN; i++)
        begin
            col1_max = rmc_pkg::rgb_max(col1_max, col1[i]);
            col2_min = rmc_pkg::rgb_min(col2_min, col2[i]);
        end
    end

    rmc_line_buf #(
        .DEPTH (MAX_LINE_WIDTH),
        .WIDTH (LBW),
        .AW    (XW)
    ) u_lb_in (
        .clk     (clk),
        .rd_en   (counted),
        .rd_addr (x_reg),
        .wr_en   (s1_v_reg && en),
        .wr_addr (s1_x_reg),
        .wr_data (lb1_wr),
        .rd_data (lb1_rd)
    );

    rmc_line_buf #(
        .DEPTH (MAX_LINE_WIDTH),
        .WIDTH (LBW),
        .AW    (XW)
    ) u_lb_s1 (
        .clk     (clk),
        .rd_en   (s2_v_reg && en),
        .rd_addr (s2_x_reg),
        .wr_en   (s3_v_reg && en),
        .wr_addr (s3_x_reg),
        .wr_data (lb2_wr),
        .rd_data (lb2_rd)
    );

    // Shift column reductions and center taps
    always_ff @(posedge clk)
    begin
        if (en && s1_v_reg)
        begin
            for (int i = 0; i < SPAN; i++)
            begin
                cmax_reg[i] <= cmax_reg[i+1];
            end
            cmax_reg[SPAN] <= col1_max;
            for (int i = 0; i < HALF; i++)
            begin
                dly1_reg[i] <= dly1_reg[i+1];
            end
            dly1_reg[HALF] <= col1[HALF];
        end
        if (en && s3_v_reg)
        begin
            for (int i = 0; i < SPAN; i++)
            begin
                cmin_reg[i] <= cmin_reg[i+1];
            end
            cmin_reg[SPAN] <= col2_min;
            for (int i = 0; i < HALF; i++)
            begin
                dly2_reg[i] <= dly2_reg[i+1];
            end
            dly2_reg[HALF] <= col2[HALF];
        end
    end

    // Dilation result for the pixel HALF lines and HALF columns back
    always_comb
    begin
        if (s2_x_reg >= XW'(HALF))
        begin
            xq = WW'(s2_x_reg) - WW'(HALF);
            yq = s2_y_reg - YW'(HALF);
        end
        else
        begin
            xq = WW'(s2_x_reg) + eff_w - WW'(HALF);
            yq = s2_y_reg - YW'(HALF + 1);
        end
        border1 = small_frame || (xq < WW'(HALF)) ||
                  ((WW+1)'(xq) + (WW+1)'(HALF) >= (WW+1)'(eff_w)) ||
                  (yq < YW'(HALF)) ||
                  ((YW+1)'(yq) + (YW+1)'(HALF) >= (YW+1)'(eff_h));
        win_max = cmax_reg[0];
        for (int i = 1; i <= SPAN; i++)
        begin
            win_max = rmc_pkg::rgb_max(win_max, cmax_reg[i]);
        end
        stage1_val = border1 ? dly1_reg[0] : win_max;
    end

    // Erosion result for the pixel SPAN lines and SPAN columns back
    always_comb
    begin
        if (s4_x_reg >= XW'(SPAN))
        begin
            xk = WW'(s4_x_reg) - WW'(SPAN);
            yk = s4_y_reg - YW'(SPAN);
        end
        else
        begin
            xk = WW'(s4_x_reg) + eff_w - WW'(SPAN);
            yk = s4_y_reg - YW'(SPAN + 1);
        end
        border2 = small_frame || (xk < WW'(HALF)) ||
                  ((WW+1)'(xk) + (WW+1)'(HALF) >= (WW+1)'(eff_w)) ||
                  (yk < YW'(HALF)) ||
                  ((YW+1)'(yk) + (YW+1)'(HALF) >= (YW+1)'(eff_h));
        win_min = cmin_reg[0];
        for (int i = 1; i <= SPAN; i++)
        begin
            win_min = rmc_pkg::rgb_min(win_min, cmin_reg[i]);
        end
        stage2_val = border2 ? dly2_reg[0] : win_min;
    end

    // Drive the result port
    assign out_valid  = out_v_reg;
    assign red_out    = out_pix_reg.r;
    assign green_out  = out_pix_reg.g;
    assign blue_out   = out_pix_reg.b;
    assign frame_last = out_last_reg;

endmodule

[src/rmc_checker.sv]
// Port-level checks for the RGB closing block, bound to its top level.
// Depends on rmc_pkg and the top level's port list only.
module rmc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [rmc_pkg::CHAN_W-1:0]       red_out,
    input logic [rmc_pkg::CHAN_W-1:0]       green_out,
    input logic [rmc_pkg::CHAN_W-1:0]       blue_out,
    input logic                             frame_last,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    // Hold a result that was not taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) &&
            $stable(green_out) && $stable(blue_out) && $stable(frame_last))
        else $error("result changed while stalled");

    // Input stalls only behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // A result leaves only through a transfer
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) && $past(rst_n) |-> $past(out_ready))
        else $error("result dropped without transfer");

    // Config port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind rgb_morphological_closing_7x7 rmc_checker u_rmc_checker (.*);

[tb/sv/tb_rgb_morphological_closing_7x7.sv]
// Self-checking testbench for rgb_morphological_closing_7x7: random and directed frames,
// a local closing predictor and an in-order result scoreboard. Depends on rmc_pkg and the RTL.
module tb_rgb_morphological_closing_7x7;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS_KEPT   = 16;
    localparam int LINE_MAX    = 1024;
    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int CUT_MAX     = 60;

    typedef struct packed {
        logic md;
        rmc_pkg::rgb_t px;
    } pix_item_t;

    typedef struct packed {
        rmc_pkg::rgb_t px;
        logic last;
    } closed_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = rmc_pkg::MODE_PIXEL;
    logic [rmc_pkg::CHAN_W-1:0] red_in = '0;
    logic [rmc_pkg::CHAN_W-1:0] green_in = '0;
    logic [rmc_pkg::CHAN_W-1:0] blue_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [rmc_pkg::CHAN_W-1:0] red_out;
    logic [rmc_pkg::CHAN_W-1:0] green_out;
    logic [rmc_pkg::CHAN_W-1:0] blue_out;
    logic frame_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rmc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    rgb_morphological_closing_7x7 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .frame_last(frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: line rings and frame position
    logic [rmc_pkg::RGB_W-1:0] src_rows [ROWS_KEPT][LINE_MAX];
    logic [rmc_pkg::RGB_W-1:0] dil_rows [ROWS_KEPT][LINE_MAX];
    logic [rmc_pkg::CFG_WIDTH_W-1:0]  width_reg = rmc_pkg::WIDTH_RESET;
    logic [rmc_pkg::CFG_HEIGHT_W-1:0] height_reg = rmc_pkg::HEIGHT_RESET;
    int col_pos = 0;
    int row_pos = 0;
    int frame_items = 0;

    pix_item_t pixel_q [$];
    closed_t   closed_q [$];
    logic [rmc_pkg::CFG_INDEX_W+rmc_pkg::CFG_DATA_W-1:0] reg_write_q [$];

    int errors = 0;
    bit steady = 1'b0;
    int hold_req = 0;
    int hold_served = 0;
    int src_gap = 0;
    int rx_gap = 0;
    int hold_cnt = 0;
    int idle_cycles = 0;

    // Free-running clock
    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return int'(width_reg);
    endfunction

    function automatic int eff_h();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // Per-channel max or min of two packed pixels
    function automatic logic [rmc_pkg::RGB_W-1:0] chan_pick(
        input logic [rmc_pkg::RGB_W-1:0] a,
        input logic [rmc_pkg::RGB_W-1:0] b,
        input bit take_max);
        logic [rmc_pkg::RGB_W-1:0] r;
        r = '0;
        for (int s = 0; s < rmc_pkg::RGB_W; s += rmc_pkg::CHAN_W) begin
            if ((a[s +: rmc_pkg::CHAN_W] > b[s +: rmc_pkg::CHAN_W]) == take_max)
                r[s +: rmc_pkg::CHAN_W] = a[s +: rmc_pkg::CHAN_W];
            else
                r[s +: rmc_pkg::CHAN_W] = b[s +: rmc_pkg::CHAN_W];
        end
        return r;
    endfunction

    function automatic bit in_ring(input int x, input int y, input int w, input int h);
        return x < 3 || x + 3 >= w || y < 3 || y + 3 >= h;
    endfunction

    // Advance the closing predictor by one accepted item
    function automatic bit closing_step(input pix_item_t it, output closed_t res);
        int w, h, e, lat, total, k, ox, oy;
        bit tiny;
        logic [rmc_pkg::RGB_W-1:0] v;
        w = eff_w();
        h = eff_h();
        tiny = (w < 7) || (h < 7);
        res = '0;
        if (it.md == rmc_pkg::MODE_PIXEL) begin
            if (row_pos >= h) return 1'b0;
            src_rows[row_pos % ROWS_KEPT][col_pos] = it.px;
            if (!tiny) begin
                if (in_ring(col_pos, row_pos, w, h))
                    dil_rows[row_pos % ROWS_KEPT][col_pos] = it.px;
                if (col_pos >= 6 && row_pos >= 6) begin
                    v = '0;
                    for (int r = row_pos - 6; r <= row_pos; r++)
                        for (int c = col_pos - 6; c <= col_pos; c++)
                            v = chan_pick(v, src_rows[r % ROWS_KEPT][c], 1'b1);
                    dil_rows[(row_pos - 3) % ROWS_KEPT][col_pos - 3] = v;
                end
            end
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end else if (row_pos < h) begin
            return 1'b0;
        end
        e = frame_items++;
        lat = 6 * w + 6;
        total = w * h;
        if (e < lat) return 1'b0;
        k = e - lat;
        if (k >= total) begin
            col_pos = 0; row_pos = 0; frame_items = 0;
            return 1'b0;
        end
        ox = k % w;
        oy = k / w;
        if (tiny || in_ring(ox, oy, w, h)) begin
            v = src_rows[oy % ROWS_KEPT][ox];
        end else begin
            v = '1;
            for (int r = oy - 3; r <= oy + 3; r++)
                for (int c = ox - 3; c <= ox + 3; c++)
                    v = chan_pick(v, dil_rows[r % ROWS_KEPT][c], 1'b0);
        end
        res.px = v;
        res.last = (k == total - 1);
        if (res.last) begin
            col_pos = 0; row_pos = 0; frame_items = 0;
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, none in steady stretches
    function automatic int gap_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (pending %0d)", what, got, want,
                 closed_q.size());
        errors++;
    endtask

    // Input driver: predict on each transfer, then offer the next queued item
    always @(posedge clk or negedge rst_n) begin : pixel_drv
        pix_item_t it;
        closed_t res;
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                it.md = mode;
                it.px = {red_in, green_in, blue_in};
                if (closing_step(it, res)) closed_q.push_back(res);
            end
            if (!in_valid || in_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    it = pixel_q.pop_front();
                    mode     <= it.md;
                    red_in   <= it.px.r;
                    green_in <= it.px.g;
                    blue_in  <= it.px.b;
                    in_valid <= 1'b1;
                    src_gap = gap_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each transfer, drive ready with stalls and holdoffs
    always @(posedge clk or negedge rst_n) begin : closed_mon
        closed_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (closed_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = closed_q.pop_front();
                    if (red_out !== want.px.r) report_mismatch("red_out", red_out, want.px.r);
                    if (green_out !== want.px.g)
                        report_mismatch("green_out", green_out, want.px.g);
                    if (blue_out !== want.px.b)
                        report_mismatch("blue_out", blue_out, want.px.b);
                    if (frame_last !== want.last)
                        report_mismatch("frame_last", frame_last, want.last);
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (hold_req != hold_served) begin
                hold_served++;
                hold_cnt = LONG_HOLD;
                out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_ready <= 1'b0;
            end else begin
                rx_gap = gap_len();
                out_ready <= 1'b1;
            end
        end
    end

    // Register write channel: apply to the predictor on transfer
    always @(posedge clk or negedge rst_n) begin : reg_drv
        logic [rmc_pkg::CFG_INDEX_W+rmc_pkg::CFG_DATA_W-1:0] wr;
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rmc_pkg::REG_IMAGE_WIDTH) begin
                    width_reg = cfg_data[rmc_pkg::CFG_WIDTH_W-1:0];
                    col_pos = 0; row_pos = 0; frame_items = 0;
                end else if (cfg_index == rmc_pkg::REG_IMAGE_HEIGHT) begin
                    height_reg = cfg_data[rmc_pkg::CFG_HEIGHT_W-1:0];
                    col_pos = 0; row_pos = 0; frame_items = 0;
                end
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_write_q.size() > 0) begin
                    wr = reg_write_q.pop_front();
                    cfg_index <= wr[rmc_pkg::CFG_INDEX_W+rmc_pkg::CFG_DATA_W-1:
                                    rmc_pkg::CFG_DATA_W];
                    cfg_data  <= wr[rmc_pkg::CFG_DATA_W-1:0];
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rgb_morphological_closing_7x7 regression: fail");
            $finish;
        end
    end

    // Wait until all traffic is done and the pipeline has emptied
    task automatic wait_quiet();
        do @(negedge clk);
        while (pixel_q.size() || in_valid || closed_q.size() || reg_write_q.size() || cfg_valid);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rmc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rmc_pkg::CFG_DATA_W-1:0] d);
        wait_quiet();
        reg_write_q.push_back({idx, d});
        wait_quiet();
    endtask

    task automatic set_size(input int w, input int h);
        if ($urandom_range(0, 3) == 0)
            write_reg(rmc_pkg::REG_IMAGE_WIDTH, {1'b1, 11'(w)});
        else
            write_reg(rmc_pkg::REG_IMAGE_WIDTH, 12'(w));
        write_reg(rmc_pkg::REG_IMAGE_HEIGHT, 12'(h));
    endtask

    function automatic rmc_pkg::rgb_t some_pixel();
        rmc_pkg::rgb_t p;
        case ($urandom_range(0, 5))
            0: p = '0;
            1: p = '1;
            2: p = {3{8'hAA}};
            3: p = {3{8'h55}};
            default: p = rmc_pkg::rgb_t'($urandom);
        endcase
        return p;
    endfunction

    // Queue one frame: pixels then drains (pixels only when cut), with optional ignored noise items
    task automatic push_frame(input int w, input int h, input int noise, input bit cut,
                              inout int count);
        int ww, hh, npix, ndrain;
        pix_item_t it;
        ww = (w == 0) ? 1 : ((w > LINE_MAX) ? LINE_MAX : w);
        hh = (h == 0) ? 1 : h;
        npix = ww * hh;
        ndrain = 6 * ww + 6;
        if (cut) npix = $urandom_range(1, (npix > CUT_MAX) ? CUT_MAX : npix - 1);
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 99) < noise) begin
                it.md = rmc_pkg::MODE_DRAIN;
                it.px = rmc_pkg::rgb_t'($urandom);
                pixel_q.push_back(it);
            end
            it.md = rmc_pkg::MODE_PIXEL;
            it.px = some_pixel();
            pixel_q.push_back(it);
        end
        count += npix;
        if (cut) return;
        for (int i = 0; i < ndrain; i++) begin
            it.md = rmc_pkg::MODE_DRAIN;
            it.px = rmc_pkg::rgb_t'($urandom);
            pixel_q.push_back(it);
            if (i < ndrain - 1 && $urandom_range(0, 99) < noise) begin
                it.md = rmc_pkg::MODE_PIXEL;
                it.px = some_pixel();
                pixel_q.push_back(it);
            end
        end
        count += ndrain;
    endtask

    initial begin : stimulus
        int count;
        int w, h;
        bit cut;
        count = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Out-of-range indexes leave the registers alone
        write_reg(2'd2, 12'hFFF);
        write_reg(2'd3, 12'h000);

        // Smallest full window frame with extreme pixels and ignored noise
        set_size(7, 7);
        push_frame(7, 7, 10, 1'b0, count);
        wait_quiet();

        // Abandoned frame, then a register write restarts
        set_size(9, 8);
        push_frame(9, 8, 0, 1'b1, count);
        wait_quiet();

        // Random frames; the first one runs under a long receiver holdoff
        count = 0;
        while (count < 1300) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                w = $urandom_range(0, 8);
                h = $urandom_range(0, 8);
            end else begin
                w = $urandom_range(7, 14);
                h = $urandom_range(7, 11);
            end
            cut = ($urandom_range(0, 9) == 0);
            if (hold_req == 0) begin
                w = 9;
                h = 8;
                cut = 1'b0;
                steady = 1'b1;
            end
            set_size(w, h);
            if (hold_req == 0) hold_req = 1;
            push_frame(w, h, ($urandom_range(0, 2) == 0) ? 4 : 0, cut, count);
            wait_quiet();
        end

        // Register extremes: clamped widest line, tallest frame, zero sizes
        steady = 1'b0;
        set_size(2047, 7);
        push_frame(2047, 7, 0, 1'b1, count);
        set_size(1, 4095);
        push_frame(1, 4095, 0, 1'b1, count);
        set_size(0, 0);
        push_frame(0, 0, 5, 1'b0, count);
        set_size(1024, 768);
        push_frame(1024, 768, 0, 1'b1, count);
        wait_quiet();

        repeat (30) @(negedge clk);
        if (errors == 0)
            $display("rgb_morphological_closing_7x7 regression: pass");
        else
            $display("rgb_morphological_closing_7x7 regression: fail");
        $finish;
    end
endmodule

[files.f]
src/rmc_pkg.sv
src/rmc_line_buf.sv
src/rgb_morphological_closing_7x7.sv
src/rmc_checker.sv
tb/sv/tb_rgb_morphological_closing_7x7.sv
